### design/pidl_pkg.sv
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int DATA_W = 32;

    // fixed field widths
    localparam int OP_W   = 2;
    localparam int POS_W  = 7;
    localparam int ST_W   = 2;
    localparam int IDX_W  = 6;
    localparam int FILL_W = 7;

    localparam logic [OP_W-1:0] OP_READ_ALL = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [ST_W-1:0]          status;
        logic signed [DATA_W-1:0] entry_value;
        logic [IDX_W-1:0]         entry_index;
        logic                     last;
        logic [FILL_W-1:0]        fill_count;
    } t_res;

endpackage

### design/positional_insert_delete_list.sv
// ----------------------------------------------------------------------------
// A word that moves no entries gives its registered result in the cycle after start.
// Insert/delete that shifts entries moves them in S_SHIFT; insert ends in S_FILL.
// Read all: entries stream out in order through S_READ, one entry per cycle.
// Rate is set by the single read and write port of the entry RAM, one move/cycle.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of signed words in a RAM with a fill count; insert and delete
// at a position by shifting entries one per cycle, and stream out on request.
// ----------------------------------------------------------------------------
module positional_insert_delete_list (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pidl_pkg::t_cmd i_cmd,
    output logic          o_res_valid,
    output pidl_pkg::t_res o_res
);
    import pidl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_FILL  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_ptr, n_ptr;
    logic [OP_W-1:0]    r_op, n_op;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [DATA_W-1:0]  r_val, n_val;
    logic               r_res_valid, n_res_valid;
    t_res               r_res, n_res;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [DATA_W-1:0]  rd_data;
    logic               ptr_last;

    pidl_ram #(
        .DATA_W(DATA_W),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign busy     = (r_state != S_IDLE);
    assign ptr_last = ((CNT_W'({1'b0, r_ptr}) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_op        = r_op;
        n_pos       = r_pos;
        n_val       = r_val;
        n_res_valid = 1'b0;
        n_res       = '0;
        wr_en       = 1'b0;
        wr_addr     = r_ptr;
        wr_data     = rd_data;
        rd_addr     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op  = i_cmd.operation;
                    n_pos = i_cmd.position;
                    n_val = i_cmd.value;
                    if (i_cmd.operation == OP_READ_ALL) begin
                        if (r_count == '0) begin
                            n_res_valid = 1'b1;
                            n_res.status = ST_EMPTY;
                            n_res.last   = 1'b1;
                        end else begin
                            n_ptr   = '0;
                            rd_addr = '0;
                            n_state = S_READ;
                        end
                    end else if (i_cmd.operation == OP_INSERT) begin
                        if (i_cmd.position > r_count) begin
                            n_res_valid      = 1'b1;
                            n_res.status     = ST_RANGE;
                            n_res.last       = 1'b1;
                            n_res.fill_count = FILL_W'(r_count);
                        end else if (r_count == CNT_W'(DEPTH)) begin
                            n_res_valid      = 1'b1;
                            n_res.status     = ST_FULL;
                            n_res.last       = 1'b1;
                            n_res.fill_count = FILL_W'(r_count);
                        end else if (i_cmd.position == r_count) begin
                            // append: nothing to move
                            wr_en            = 1'b1;
                            wr_addr          = i_cmd.position[ADDR_W-1:0];
                            wr_data          = i_cmd.value;
                            n_count          = r_count + CNT_W'(1);
                            n_res_valid      = 1'b1;
                            n_res.status     = ST_OK;
                            n_res.last       = 1'b1;
                            n_res.fill_count = FILL_W'(n_count);
                        end else begin
                            // move entries up, starting from the top one
                            n_ptr   = ADDR_W'(r_count - CNT_W'(1));
                            rd_addr = n_ptr;
                            n_state = S_SHIFT;
                        end
                    end else if (i_cmd.operation == OP_DELETE) begin
                        if (i_cmd.position >= r_count) begin
                            n_res_valid      = 1'b1;
                            n_res.status     = ST_RANGE;
                            n_res.last       = 1'b1;
                            n_res.fill_count = FILL_W'(r_count);
                        end else if ((i_cmd.position + POS_W'(1)) == r_count) begin
                            // drop the top entry: nothing to move
                            n_count          = r_count - CNT_W'(1);
                            n_res_valid      = 1'b1;
                            n_res.status     = ST_OK;
                            n_res.last       = 1'b1;
                            n_res.fill_count = FILL_W'(n_count);
                        end else begin
                            n_ptr   = i_cmd.position[ADDR_W-1:0] + ADDR_W'(1);
                            rd_addr = n_ptr;
                            n_state = S_SHIFT;
                        end
                    end
                end
            end
            S_READ: begin
                n_res_valid       = 1'b1;
                n_res.status      = ST_OK;
                n_res.entry_value = rd_data;
                n_res.entry_index = IDX_W'(r_ptr);
                n_res.last        = ptr_last;
                n_res.fill_count  = FILL_W'(r_count);
                if (ptr_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr   = r_ptr + ADDR_W'(1);
                    rd_addr = n_ptr;
                end
            end
            S_SHIFT: begin
                wr_en   = 1'b1;
                wr_data = rd_data;
                if (r_op == OP_INSERT) begin
                    wr_addr = r_ptr + ADDR_W'(1);
                    if (r_ptr == r_pos[ADDR_W-1:0]) begin
                        n_state = S_FILL;
                    end else begin
                        n_ptr   = r_ptr - ADDR_W'(1);
                        rd_addr = n_ptr;
                    end
                end else begin
                    wr_addr = r_ptr - ADDR_W'(1);
                    if (ptr_last) begin
                        n_count          = r_count - CNT_W'(1);
                        n_res_valid      = 1'b1;
                        n_res.status     = ST_OK;
                        n_res.last       = 1'b1;
                        n_res.fill_count = FILL_W'(n_count);
                        n_state          = S_IDLE;
                    end else begin
                        n_ptr   = r_ptr + ADDR_W'(1);
                        rd_addr = n_ptr;
                    end
                end
            end
            S_FILL: begin
                // hole is open: place the new word
                wr_en            = 1'b1;
                wr_addr          = r_pos[ADDR_W-1:0];
                wr_data          = r_val;
                n_count          = r_count + CNT_W'(1);
                n_res_valid      = 1'b1;
                n_res.status     = ST_OK;
                n_res.last       = 1'b1;
                n_res.fill_count = FILL_W'(n_count);
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_op  <= n_op;
        r_pos <= n_pos;
        r_val <= n_val;
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // the read issued on the final move is dropped, so only check ongoing moves
    a_shift_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SHIFT) && (n_state == S_SHIFT)) |-> (wr_addr != rd_addr))
        else $error("shift reads the entry it writes");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != ST_OK)) |-> o_res.last)
        else $error("error result not marked last");

    a_stream_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.last) |-> busy)
        else $error("non-final word while idle");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_count == $past(r_count))
            || (r_count == ($past(r_count) + CNT_W'(1)))
            || (r_count == ($past(r_count) - CNT_W'(1)))))
        else $error("fill count moved by more than one");

endmodule

### design/pidl_ram.sv
// ----------------------------------------------------------------------------
// pidl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pidl_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
